// ===== hdl/cbm68_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm68_pkg
// Shared types and constants of the cartridge bank mapper: beat layouts,
// operation and target codes, ROM address widths and the register file.
// ----------------------------------------------------------------------------
package cbm68_pkg;

    localparam int PRG_ADDR_BITS = 18;
    localparam int CHR_ADDR_BITS = 18;
    localparam int MAP_ADDR_BITS = 18;

    localparam logic [1:0] OP_REG_WRITE = 2'd0;
    localparam logic [1:0] OP_CPU_READ  = 2'd1;
    localparam logic [1:0] OP_PPU_READ  = 2'd2;

    localparam logic [1:0] TGT_NONE  = 2'd0;
    localparam logic [1:0] TGT_PRG   = 2'd1;
    localparam logic [1:0] TGT_CHR   = 2'd2;
    localparam logic [1:0] TGT_CIRAM = 2'd3;

    localparam logic [3:0] REG_CHR0   = 4'h8;
    localparam logic [3:0] REG_CHR1   = 4'h9;
    localparam logic [3:0] REG_CHR2   = 4'hA;
    localparam logic [3:0] REG_CHR3   = 4'hB;
    localparam logic [3:0] REG_NT0    = 4'hC;
    localparam logic [3:0] REG_NT1    = 4'hD;
    localparam logic [3:0] REG_CTRL   = 4'hE;
    localparam logic [3:0] REG_PRG    = 4'hF;

    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_SCREEN0    = 2'd2;
    localparam logic [1:0] MIR_SCREEN1    = 2'd3;

    localparam logic [4:0] PRG_BANK_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]                 target;
        logic [MAP_ADDR_BITS-1:0]   mapped_address;
    } t_out_beat;

    typedef struct packed {
        logic [3:0][7:0] chr_bank;
        logic [1:0][7:0] nametable_page;
        logic            nametable_from_rom;
        logic [1:0]      mirror_mode;
        logic [7:0]      prg_bank;
    } t_map_state;

endpackage

// ===== hdl/cbm68_xlate.sv =====
// ----------------------------------------------------------------------------
// cbm68_xlate
// Decodes one beat: applies a register write to the bank registers, or
// translates a CPU or PPU address into a PRG, CHR or nametable address.
// ----------------------------------------------------------------------------
module cbm68_xlate
    import cbm68_pkg::*;
(
    input  t_in_beat   i_beat,
    input  t_map_state i_state,
    input  logic [4:0] i_prg_bank_count,
    output t_out_beat  o_result,
    output t_map_state o_state
);

    logic [7:0]  last_bank;
    logic [7:0]  cpu_bank;
    logic [21:0] prg_full;
    logic [13:0] ppu_addr;
    logic [18:0] chr_full;
    logic [17:0] ntrom_full;
    logic        page;
    logic [7:0]  nt_page;

    always_comb begin
        last_bank  = 8'({3'b000, i_prg_bank_count} - 8'd1);
        cpu_bank   = i_beat.bus_address[14] ? last_bank : i_state.prg_bank;
        prg_full   = {cpu_bank, i_beat.bus_address[13:0]};
        ppu_addr   = i_beat.bus_address[13:0];
        chr_full   = {i_state.chr_bank[ppu_addr[12:11]], ppu_addr[10:0]};
        unique case (i_state.mirror_mode)
            MIR_VERTICAL:   page = ppu_addr[10];
            MIR_HORIZONTAL: page = ppu_addr[11];
            MIR_SCREEN0:    page = 1'b0;
            MIR_SCREEN1:    page = 1'b1;
            default:        page = 1'b0;
        endcase
        nt_page    = i_state.nametable_page[page];
        ntrom_full = {nt_page, ppu_addr[9:0]};
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_beat.operation)
            OP_REG_WRITE: begin
                if (i_beat.bus_address[15]) begin
                    unique case (i_beat.bus_address[15:12])
                        REG_CHR0: o_state.chr_bank[0] = i_beat.write_data;
                        REG_CHR1: o_state.chr_bank[1] = i_beat.write_data;
                        REG_CHR2: o_state.chr_bank[2] = i_beat.write_data;
                        REG_CHR3: o_state.chr_bank[3] = i_beat.write_data;
                        REG_NT0: o_state.nametable_page[0] = i_beat.write_data | 8'h80;
                        REG_NT1: o_state.nametable_page[1] = i_beat.write_data | 8'h80;
                        REG_CTRL: begin
                            o_state.nametable_from_rom = i_beat.write_data[4];
                            o_state.mirror_mode        = i_beat.write_data[1:0];
                        end
                        REG_PRG: o_state.prg_bank = i_beat.write_data;
                        default: o_state = i_state;
                    endcase
                end
            end
            OP_CPU_READ: begin
                if (i_beat.bus_address[15]) begin
                    o_result.target         = TGT_PRG;
                    o_result.mapped_address = MAP_ADDR_BITS'(prg_full[PRG_ADDR_BITS-1:0]);
                end
            end
            OP_PPU_READ: begin
                if (!ppu_addr[13]) begin
                    o_result.target         = TGT_CHR;
                    o_result.mapped_address = MAP_ADDR_BITS'(chr_full[CHR_ADDR_BITS-1:0]);
                end else if (ppu_addr[13:8] != 6'h3F) begin
                    if (i_state.nametable_from_rom) begin
                        o_result.target         = TGT_CHR;
                        o_result.mapped_address =
                            MAP_ADDR_BITS'(ntrom_full[CHR_ADDR_BITS-1:0]);
                    end else begin
                        o_result.target         = TGT_CIRAM;
                        o_result.mapped_address =
                            MAP_ADDR_BITS'({page, ppu_addr[9:0]});
                    end
                end
            end
            default: o_result = '0;
        endcase
    end

endmodule

// ===== hdl/cartridge_bank_mapper_68_top.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_68_top
// Bank mapper of the Sunsoft-4 kind: register writes and CPU/PPU address
// translation to PRG ROM, CHR ROM or console nametable RAM.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_ready    i_in_beat  (t_in_beat)
//   out       output     o_out_valid / i_out_ready  o_out_beat (t_out_beat)
//   cfg       input      i_cfg_we                   i_cfg_data (bank count)
//
// A beat is loaded into the input register when it is accepted, and its result
// into the result register when that register can advance; a stall on the output
// side holds the beat in the input register until the waiting result is taken.
// One beat is accepted every cycle while the output side takes results.
// The bank registers change as a write beat leaves the input register.
// Reset empties both registers and clears all bank registers.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_68_top
    import cbm68_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_beat   i_in_beat,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_beat,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_beat   r_in_beat;
    logic       r_out_valid;
    t_out_beat  r_out_beat;
    t_map_state r_state;
    logic [4:0] r_prg_bank_count;

    logic       advance;
    t_out_beat  n_out_beat;
    t_map_state n_state;

    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    cbm68_xlate u_xlate (
        .i_beat           (r_in_beat),
        .i_state          (r_state),
        .i_prg_bank_count (r_prg_bank_count),
        .o_result         (n_out_beat),
        .o_state          (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_state          <= '0;
            r_prg_bank_count <= PRG_BANK_COUNT_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
            if (i_cfg_we) begin
                r_prg_bank_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
        if (advance && r_in_valid) begin
            r_out_beat <= n_out_beat;
        end
    end

    a_none_has_zero_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat.target == TGT_NONE) |-> r_out_beat.mapped_address == '0)
        else $error("result with no target carries a nonzero address");

    a_state_holds_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |=> $stable(r_state))
        else $error("bank registers changed without a beat in the input register");

    a_nametable_page_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.nametable_page[0] == 8'h00 || r_state.nametable_page[0][7]) &&
        (r_state.nametable_page[1] == 8'h00 || r_state.nametable_page[1][7]))
        else $error("nametable page stored without bit 7 set");

endmodule
